FILE: rtl/core/crnp_pkg.sv
// ============================================================================
// crnp_pkg: shared definitions for the custom radix number parser
// Character codes, configuration register indexes, fixed field widths, the
// alphabet lookup result bundle and the character class helpers.
// ============================================================================
package crnp_pkg;

    // Fixed storage: two 64-bit registers of eight byte-wide symbols each.
    localparam int SYMBOL_W   = 8;
    localparam int SYMBOL_CAP = 16;
    localparam int DIGIT_W    = 4;
    localparam int LEN_W      = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    // Defaults for the top-level parameters.
    localparam int MAX_SYMBOLS_DEFAULT = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN   = 2'd2;

    // Character codes.
    localparam logic [SYMBOL_W-1:0] CHAR_NUL     = 8'd0;
    localparam logic [SYMBOL_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [SYMBOL_W-1:0] CHAR_PLUS    = 8'd43;
    localparam logic [SYMBOL_W-1:0] CHAR_MINUS   = 8'd45;
    localparam logic [SYMBOL_W-1:0] CHAR_CTRL_LO = 8'd9;
    localparam logic [SYMBOL_W-1:0] CHAR_CTRL_HI = 8'd13;

    // Result of the alphabet analysis and the digit lookup of one byte.
    typedef struct packed {
        logic               ok;
        logic               hit;
        logic [DIGIT_W-1:0] digit;
        logic [LEN_W-1:0]   radix;
    } alpha_info_t;

    // Space or one of the control bytes from tab to carriage return.
    function automatic logic is_blank(input logic [SYMBOL_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_CTRL_LO) && (c <= CHAR_CTRL_HI));
    endfunction

    function automatic logic is_sign(input logic [SYMBOL_W-1:0] c);
        return (c == CHAR_PLUS) || (c == CHAR_MINUS);
    endfunction

endpackage

FILE: rtl/core/crnp_alphabet.sv
// ============================================================================
// crnp_alphabet: alphabet check and digit lookup
// Finds the symbols in use, checks the alphabet for validity and returns the
// lowest position that holds the current byte, all in parallel compares.
// ============================================================================
module crnp_alphabet #(
    parameter int MAX_SYMBOLS = crnp_pkg::MAX_SYMBOLS_DEFAULT
) (
    input  logic [crnp_pkg::CFG_W-1:0]    alphabet_low,
    input  logic [crnp_pkg::CFG_W-1:0]    alphabet_high,
    input  logic [crnp_pkg::LEN_W-1:0]    base_len,
    input  logic [crnp_pkg::SYMBOL_W-1:0] char_byte,
    output crnp_pkg::alpha_info_t         info
);

    logic [crnp_pkg::SYMBOL_CAP-1:0][crnp_pkg::SYMBOL_W-1:0] symbols;
    logic [crnp_pkg::LEN_W-1:0] n_clamp;
    logic [MAX_SYMBOLS-1:0]     active;
    logic [crnp_pkg::LEN_W-1:0] alpha_len;
    logic                       alive;
    logic                       bad_symbol;
    logic                       hit;
    logic [crnp_pkg::DIGIT_W-1:0] digit;

    // Symbol k sits in byte k of the concatenated registers.
    assign symbols = {alphabet_high, alphabet_low};

    // A radix above the symbol capacity is treated as the capacity.
    assign n_clamp = (base_len > crnp_pkg::LEN_W'(MAX_SYMBOLS))
                   ? crnp_pkg::LEN_W'(MAX_SYMBOLS) : base_len;

    // The alphabet ends at base_len or at the first zero symbol.
    always_comb
    begin
        alive = 1'b1;
        for (int k = 0; k < MAX_SYMBOLS; k++)
        begin
            alive = alive && (crnp_pkg::LEN_W'(k) < n_clamp) && (symbols[k] != '0);
            active[k] = alive;
        end
    end

    assign alpha_len = crnp_pkg::LEN_W'($countones(active));

    // Invalid when a sign or blank is present or a symbol repeats.
    always_comb
    begin
        bad_symbol = 1'b0;
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (active[i] && (crnp_pkg::is_sign(symbols[i]) ||
                              crnp_pkg::is_blank(symbols[i])))
            begin
                bad_symbol = 1'b1;
            end
            for (int j = i + 1; j < MAX_SYMBOLS; j++)
            begin
                if (active[j] && (symbols[i] == symbols[j]))
                begin
                    bad_symbol = 1'b1;
                end
            end
        end
    end

    // Lowest matching position wins. Active symbols are never zero, so a
    // zero byte never matches.
    always_comb
    begin
        hit   = 1'b0;
        digit = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--)
        begin
            if (active[k] && (symbols[k] == char_byte))
            begin
                hit   = 1'b1;
                digit = crnp_pkg::DIGIT_W'(k);
            end
        end
    end

    always_comb
    begin
        info.ok    = (alpha_len >= crnp_pkg::LEN_W'(2)) && !bad_symbol;
        info.hit   = hit;
        info.digit = digit;
        info.radix = alpha_len;
    end

endmodule

FILE: rtl/core/crnp_parse_core.sv
// ============================================================================
// crnp_parse_core: parse state, accumulator and result register
// Steps the skip, sign, digit and ignore phases once per byte, does the
// multiply-add on each digit and captures the result on a zero byte.
// ============================================================================
module crnp_parse_core #(
    parameter int VALUE_WIDTH = crnp_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [crnp_pkg::SYMBOL_W-1:0] char_byte,
    input  crnp_pkg::alpha_info_t         info,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [VALUE_WIDTH-1:0]        result_value,
    output logic                          result_ok,
    output logic                          result_busy
);

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGIT  = 4'b0100,
        PH_IGNORE = 4'b1000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   negate_reg, negate_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                   ok_reg, ok_next;
    logic [VALUE_WIDTH-1:0] radix_ext;
    logic [VALUE_WIDTH-1:0] acc_mac;
    logic [VALUE_WIDTH-1:0] acc_signed;
    logic                   res_load;

    // One digit: accumulator times radix plus digit, wrapping.
    assign radix_ext  = VALUE_WIDTH'(info.radix);
    assign acc_mac    = (acc_reg * radix_ext) + VALUE_WIDTH'(info.digit);
    assign acc_signed = negate_reg ? ('0 - acc_reg) : acc_reg;

    // The result register is full and held by the receiver.
    assign result_busy = out_valid_reg && out_stall;

    // Phase transitions and accumulator update.
    always_comb
    begin
        phase_next  = phase_reg;
        negate_next = negate_reg;
        acc_next    = acc_reg;
        res_load    = 1'b0;
        if (step)
        begin
            if (char_byte == crnp_pkg::CHAR_NUL)
            begin
                res_load    = 1'b1;
                phase_next  = PH_SKIP;
                negate_next = 1'b0;
                acc_next    = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_SKIP, PH_SIGN:
                    begin
                        if (!((phase_reg == PH_SKIP) && crnp_pkg::is_blank(char_byte)))
                        begin
                            if (crnp_pkg::is_sign(char_byte))
                            begin
                                negate_next = negate_reg ^ (char_byte == crnp_pkg::CHAR_MINUS);
                                phase_next  = PH_SIGN;
                            end
                            else if (info.hit)
                            begin
                                acc_next   = acc_mac;
                                phase_next = PH_DIGIT;
                            end
                            else
                            begin
                                phase_next = PH_IGNORE;
                            end
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (info.hit)
                        begin
                            acc_next = acc_mac;
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                    PH_IGNORE:
                    begin
                        phase_next = PH_IGNORE;
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end
    end

    // Result register: loads on a zero byte, holds while stalled.
    assign out_valid_next = res_load || result_busy;
    assign value_next     = res_load ? (info.ok ? acc_signed : '0) : value_reg;
    assign ok_next        = res_load ? info.ok : ok_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            negate_reg    <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            negate_reg    <= negate_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        ok_reg    <= ok_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign result_ok    = ok_reg;

endmodule

FILE: rtl/core/custom_radix_number_parser.sv
// ============================================================================
// custom_radix_number_parser: signed integer parser with a configured alphabet
// Takes one string byte per transaction and emits one value per zero byte.
// A zero byte passes the input register and then loads the result register,
// which offers its value; a held result keeps the zero byte in the input register.
// Throughput: one byte per cycle unless a zero byte waits on a held result,
// set by the single-step phase and multiply-add update of the accumulator.
// Reset clears the configuration registers, the parse state and both valids.
// ============================================================================
module custom_radix_number_parser #(
    parameter int MAX_SYMBOLS = crnp_pkg::MAX_SYMBOLS_DEFAULT,
    parameter int VALUE_WIDTH = crnp_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [crnp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crnp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [crnp_pkg::SYMBOL_W-1:0]  char_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [VALUE_WIDTH-1:0]  value,
    output logic                           base_valid
);

    logic [crnp_pkg::CFG_W-1:0]    alpha_low_reg;
    logic [crnp_pkg::CFG_W-1:0]    alpha_high_reg;
    logic [crnp_pkg::LEN_W-1:0]    base_len_reg;
    logic                          s1_valid_reg, s1_valid_next;
    logic [crnp_pkg::SYMBOL_W-1:0] char_reg;
    logic                          s1_zero;
    logic                          step;
    logic                          accept;
    logic                          result_busy;
    logic [VALUE_WIDTH-1:0]        result_value;
    crnp_pkg::alpha_info_t         info;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            base_len_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                crnp_pkg::CFG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                crnp_pkg::CFG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                crnp_pkg::CFG_BASE_LEN:   base_len_reg   <= cfg_data[crnp_pkg::LEN_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Input register: the byte moves on unless it is a zero byte and the
    // result register is still held.
    assign s1_zero       = (char_reg == crnp_pkg::CHAR_NUL);
    assign step          = s1_valid_reg && !(s1_zero && result_busy);
    assign in_stall      = s1_valid_reg && !step;
    assign accept        = in_valid && !in_stall;
    assign s1_valid_next = accept || (s1_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_in;
        end
    end

    // Alphabet analysis and digit lookup of the held byte.
    crnp_alphabet #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alphabet (
        .alphabet_low  (alpha_low_reg),
        .alphabet_high (alpha_high_reg),
        .base_len      (base_len_reg),
        .char_byte     (char_reg),
        .info          (info)
    );

    // Parse state and result register.
    crnp_parse_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_byte    (char_reg),
        .info         (info),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .result_ok    (base_valid),
        .result_busy  (result_busy)
    );

    assign value = $signed(result_value);

    // A zero byte that moves on always produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && s1_zero) |=> out_valid)
    else $error("zero byte did not produce a result");

    // No result appears without a zero byte moving on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(step && s1_zero)) |=> !out_valid)
    else $error("result appeared without a zero byte");

    // An invalid alphabet always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !base_valid) |-> (result_value == '0))
    else $error("nonzero value with invalid alphabet");

endmodule

FILE: bench/tb_custom_radix_number_parser.sv
// ============================================================================
// tb_custom_radix_number_parser: self-checking bench for the radix parser
// Streams string bytes through the parser and compares every emitted value
// and alphabet flag with a predictor of the parse rules held in the bench.
// Both channels idle at random, and one long output hold fills the block.
// ============================================================================
module tb_custom_radix_number_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW             = crnp_pkg::VALUE_WIDTH_DEFAULT;
    localparam int SYMBOL_LIMIT   = crnp_pkg::MAX_SYMBOLS_DEFAULT;
    localparam int RESULT_LATENCY = 2;
    localparam int IDLE_LIMIT     = 4000;
    localparam int RANDOM_BYTES   = 1500;

    // Receiver stall styles.
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    // Flavors of randomly built alphabets.
    localparam int ALPHA_OVERSIZE    = 0;
    localparam int ALPHA_ZERO_SYMBOL = 1;
    localparam int ALPHA_REPEAT      = 2;
    localparam int ALPHA_BAD_SYMBOL  = 3;
    localparam int ALPHA_SHORT       = 4;

    typedef enum logic [1:0] {SCAN_BLANKS, SCAN_SIGNS, SCAN_DIGITS, SCAN_REST} scan_state_t;

    typedef struct packed {
        logic [VW-1:0] number;
        logic          valid_base;
    } parse_result_t;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            cfg_write  = 1'b0;
    logic [crnp_pkg::CFG_IDX_W-1:0]  cfg_index  = crnp_pkg::CFG_ALPHA_LOW;
    logic [crnp_pkg::CFG_W-1:0]      cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [crnp_pkg::SYMBOL_W-1:0]   char_in    = crnp_pkg::CHAR_NUL;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic signed [VW-1:0]            value;
    logic                            base_valid;

    // Predictor copy of the registers and the parse state.
    logic [crnp_pkg::CFG_W-1:0]      alpha_lo_q = '0;
    logic [crnp_pkg::CFG_W-1:0]      alpha_hi_q = '0;
    logic [crnp_pkg::LEN_W-1:0]      radix_cfg  = '0;
    scan_state_t                     scan_state = SCAN_BLANKS;
    logic                            minus_odd  = 1'b0;
    logic [VW-1:0]                   acc        = '0;

    parse_result_t         expected_results[$];
    parse_result_t         head_result;

    int mismatches  = 0;
    int bytes_sent  = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int stall_style = STALL_NONE;
    int hold_serial = 0;
    int hold_length = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_tick  = 0;
    int idle_cycles = 0;

    custom_radix_number_parser i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .base_valid (base_valid)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Symbol k of the configured alphabet storage.
    function automatic logic [crnp_pkg::SYMBOL_W-1:0] symbol(input int k);
        logic [2*crnp_pkg::CFG_W-1:0] all;
        all = {alpha_hi_q, alpha_lo_q};
        return all[crnp_pkg::SYMBOL_W*k +: crnp_pkg::SYMBOL_W];
    endfunction

    // The radix: the length clamped to the storage, cut at the first zero symbol.
    function automatic int symbols_in_use();
        int n;
        n = (radix_cfg > SYMBOL_LIMIT) ? SYMBOL_LIMIT : int'(radix_cfg);
        for (int k = 0; k < n; k++)
            if (symbol(k) == crnp_pkg::CHAR_NUL)
                return k;
        return n;
    endfunction

    function automatic logic blank_char(input logic [crnp_pkg::SYMBOL_W-1:0] c);
        return (c == crnp_pkg::CHAR_SPACE) ||
               (c >= crnp_pkg::CHAR_CTRL_LO && c <= crnp_pkg::CHAR_CTRL_HI);
    endfunction

    function automatic logic sign_char(input logic [crnp_pkg::SYMBOL_W-1:0] c);
        return (c == crnp_pkg::CHAR_MINUS) || (c == crnp_pkg::CHAR_PLUS);
    endfunction

    function automatic logic alphabet_valid();
        int n;
        logic [crnp_pkg::SYMBOL_W-1:0] s;
        n = symbols_in_use();
        if (n < 2)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            s = symbol(i);
            if (sign_char(s) || blank_char(s))
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (symbol(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Lowest alphabet position holding c, or -1 when c is no digit.
    function automatic int digit_value(input logic [crnp_pkg::SYMBOL_W-1:0] c);
        int n;
        n = symbols_in_use();
        if (c == crnp_pkg::CHAR_NUL)
            return -1;
        for (int k = 0; k < n; k++)
            if (symbol(k) == c)
                return k;
        return -1;
    endfunction

    function automatic logic [2*crnp_pkg::CFG_W-1:0] pack_symbols(input string s);
        logic [2*crnp_pkg::CFG_W-1:0] word;
        word = '0;
        for (int i = 0; i < s.len() && i < SYMBOL_LIMIT; i++)
            word[crnp_pkg::SYMBOL_W*i +: crnp_pkg::SYMBOL_W] = s[i];
        return word;
    endfunction

    // Advance the predicted parse by one accepted byte.
    task automatic parse_byte(input logic [crnp_pkg::SYMBOL_W-1:0] c);
        int d;
        logic ok;
        parse_result_t r;
        d = -1;
        if (c == crnp_pkg::CHAR_NUL)
        begin
            ok = alphabet_valid();
            r.valid_base = ok;
            r.number = '0;
            if (ok)
                r.number = minus_odd ? -acc : acc;
            expected_results.push_back(r);
            scan_state = SCAN_BLANKS;
            minus_odd = 1'b0;
            acc = '0;
            return;
        end
        case (scan_state)
            SCAN_BLANKS, SCAN_SIGNS:
            begin
                // Blanks are skipped only ahead of the first sign or digit.
                if (scan_state == SCAN_BLANKS && blank_char(c))
                    scan_state = SCAN_BLANKS;
                else if (sign_char(c))
                begin
                    minus_odd ^= (c == crnp_pkg::CHAR_MINUS);
                    scan_state = SCAN_SIGNS;
                end
                else
                begin
                    d = digit_value(c);
                    if (d < 0)
                        scan_state = SCAN_REST;
                    else
                        scan_state = SCAN_DIGITS;
                end
            end
            SCAN_DIGITS:
            begin
                d = digit_value(c);
                if (d < 0)
                    scan_state = SCAN_REST;
            end
            default:
                d = -1;
        endcase
        if (d >= 0)
            acc = acc * VW'(symbols_in_use()) + VW'(d);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one byte, with a random gap at the start of each burst.
    task automatic send_char(input logic [crnp_pkg::SYMBOL_W-1:0] c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit terminate);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        if (terminate)
            send_char(crnp_pkg::CHAR_NUL);
    endtask

    // Stop offering, wait for every pending value and let the pipeline drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 6) @(posedge clk);
    endtask

    // Write all three registers while the parser is idle.
    task automatic load_alphabet(input logic [2*crnp_pkg::CFG_W-1:0] symbols,
                                 input logic [crnp_pkg::CFG_W-1:0] len_word);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= crnp_pkg::CFG_ALPHA_LOW;
        cfg_data  <= symbols[crnp_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= crnp_pkg::CFG_ALPHA_HIGH;
        cfg_data  <= symbols[2*crnp_pkg::CFG_W-1:crnp_pkg::CFG_W];
        @(posedge clk);
        cfg_index <= crnp_pkg::CFG_BASE_LEN;
        cfg_data  <= len_word;
        @(posedge clk);
        cfg_write <= 1'b0;
        alpha_lo_q = symbols[crnp_pkg::CFG_W-1:0];
        alpha_hi_q = symbols[2*crnp_pkg::CFG_W-1:crnp_pkg::CFG_W];
        radix_cfg  = len_word[crnp_pkg::LEN_W-1:0];
    endtask

    // One string: mostly blanks, signs and alphabet digits, sometimes noise.
    task automatic send_random_string(input bit terminate);
        int n;
        int count;
        logic [crnp_pkg::SYMBOL_W-1:0] c;
        n = symbols_in_use();
        if ($urandom_range(0, 9) < 8)
        begin
            repeat ($urandom_range(0, 3))
            begin
                c = crnp_pkg::SYMBOL_W'($urandom_range(crnp_pkg::CHAR_CTRL_LO,
                                                       crnp_pkg::CHAR_CTRL_HI + 1));
                if (c > crnp_pkg::CHAR_CTRL_HI)
                    c = crnp_pkg::CHAR_SPACE;
                send_char(c);
            end
            repeat ($urandom_range(0, 3))
                send_char($urandom_range(0, 1) ? crnp_pkg::CHAR_MINUS : crnp_pkg::CHAR_PLUS);
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
            repeat (count)
            begin
                if (n > 0)
                    c = symbol($urandom_range(0, n - 1));
                else
                    c = crnp_pkg::SYMBOL_W'($urandom_range(1, 255));
                send_char(c);
            end
            repeat ($urandom_range(0, 2))
                send_char(crnp_pkg::SYMBOL_W'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 8))
                send_char(crnp_pkg::SYMBOL_W'($urandom_range(1, 255)));
        end
        if (terminate)
            send_char(crnp_pkg::CHAR_NUL);
    endtask

    // Registers at their reset value: the alphabet is empty and invalid.
    task automatic test_unconfigured();
        send_text("7", 1'b1);
        send_text("", 1'b1);
    endtask

    // Hex digits with an oversized length, most negative value and wraparound.
    task automatic test_hex_oversized();
        load_alphabet(pack_symbols("0123456789abcdef"), 64'd31);
        stall_style = STALL_LIGHT;
        gap_max = 2;
        send_text("\015 -80000000\3771", 1'b1);
        send_text("\t-+-100000000f", 1'b1);
        send_text("+-", 1'b1);
    endtask

    // A zero symbol cuts the alphabet short, leaving a binary radix.
    task automatic test_zero_symbol();
        load_alphabet(pack_symbols("01"), 64'd16);
        send_text("\013-101", 1'b1);
    endtask

    // A sign in the alphabet, then a repeated symbol: both give zero.
    task automatic test_invalid_alphabets();
        load_alphabet(pack_symbols("0+"), 64'd2);
        send_text("0", 1'b1);
        load_alphabet(pack_symbols("aba"), 64'd3);
        send_text("b", 1'b1);
    endtask

    // The radix changes between two digits of one string.
    task automatic test_config_mid_string();
        load_alphabet(pack_symbols("01"), 64'd2);
        send_text("11", 1'b0);
        load_alphabet(pack_symbols("012"), 64'd3);
        send_text("2", 1'b1);
    endtask

    // Hold the output for a long stretch while strings keep coming.
    task automatic test_backpressure();
        load_alphabet(pack_symbols("0123456789"), 64'd10);
        stall_style = STALL_NONE;
        gap_max = 0;
        hold_length = 300;
        hold_serial++;
        repeat (40) send_random_string(1'b1);
    endtask

    // Random alphabets, mostly valid, each followed by a run of strings.
    task automatic test_random();
        logic [2*crnp_pkg::CFG_W-1:0] word;
        logic [crnp_pkg::SYMBOL_W-1:0] c;
        int start;
        int n;
        int mode;
        int len;
        int i;
        int j;
        int count;
        bit dup;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            for (int k = 0; k < 4; k++)
                word[32*k +: 32] = $urandom;
            n = ($urandom_range(0, 2) == 0) ? SYMBOL_LIMIT : $urandom_range(2, SYMBOL_LIMIT);
            // Distinct symbols that are neither blanks nor signs.
            for (i = 0; i < n; i++)
            begin
                do
                begin
                    c = crnp_pkg::SYMBOL_W'($urandom_range(1, 255));
                    dup = 1'b0;
                    for (j = 0; j < i; j++)
                        if (word[crnp_pkg::SYMBOL_W*j +: crnp_pkg::SYMBOL_W] == c)
                            dup = 1'b1;
                end
                while (dup || blank_char(c) || sign_char(c));
                word[crnp_pkg::SYMBOL_W*i +: crnp_pkg::SYMBOL_W] = c;
            end
            len = n;
            mode = $urandom_range(0, 9);
            case (mode)
                ALPHA_OVERSIZE:
                    len = $urandom_range(SYMBOL_LIMIT + 1, 31);
                ALPHA_ZERO_SYMBOL:
                begin
                    if (n < SYMBOL_LIMIT)
                    begin
                        word[crnp_pkg::SYMBOL_W*n +: crnp_pkg::SYMBOL_W] = crnp_pkg::CHAR_NUL;
                        len = $urandom_range(n + 1, 31);
                    end
                end
                ALPHA_REPEAT:
                begin
                    j = $urandom_range(1, n - 1);
                    i = $urandom_range(0, j - 1);
                    word[crnp_pkg::SYMBOL_W*j +: crnp_pkg::SYMBOL_W] =
                        word[crnp_pkg::SYMBOL_W*i +: crnp_pkg::SYMBOL_W];
                end
                ALPHA_BAD_SYMBOL:
                begin
                    i = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 3))
                        0: c = crnp_pkg::CHAR_PLUS;
                        1: c = crnp_pkg::CHAR_MINUS;
                        2: c = crnp_pkg::CHAR_SPACE;
                        default: c = crnp_pkg::SYMBOL_W'($urandom_range(crnp_pkg::CHAR_CTRL_LO,
                                                                        crnp_pkg::CHAR_CTRL_HI));
                    endcase
                    word[crnp_pkg::SYMBOL_W*i +: crnp_pkg::SYMBOL_W] = c;
                end
                ALPHA_SHORT:
                    len = $urandom_range(0, 1);
                default:
                    len = n;
            endcase
            load_alphabet(word, {$urandom, 27'($urandom), 5'(len)});
            stall_style = $urandom_range(STALL_NONE, STALL_PERIODIC);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            count = $urandom_range(4, 20);
            // The last string is sometimes left open across the next write.
            for (int k = 0; k < count; k++)
                send_random_string(k < count - 1 || $urandom_range(0, 3) != 0);
        end
    endtask

    // Output stall: a requested long hold first, otherwise the current style.
    always @(posedge clk)
    begin
        if (hold_serial != hold_seen)
        begin
            hold_seen = hold_serial;
            hold_left = hold_length;
        end
        stall_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_style)
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: out_stall <= ((stall_tick % 11) < 4);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    // Compare each output transaction with the oldest predicted value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("value with no string pending", value, '0);
            else
            begin
                head_result = expected_results.pop_front();
                if (value !== head_result.number)
                    report_mismatch("value", value, head_result.number);
                if (base_valid !== head_result.valid_base)
                    report_mismatch("base_valid", base_valid, head_result.valid_base);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_custom_radix_number_parser failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unconfigured();
        test_hex_oversized();
        test_zero_symbol();
        test_invalid_alphabets();
        test_config_mid_string();
        test_backpressure();
        test_random();
        settle();
        if (mismatches == 0)
            $display("tb_custom_radix_number_parser passed");
        else
            $display("tb_custom_radix_number_parser failed");
        $finish;
    end

endmodule

FILE: custom_radix_number_parser.f
rtl/core/crnp_pkg.sv
rtl/core/crnp_alphabet.sv
rtl/core/crnp_parse_core.sv
rtl/core/custom_radix_number_parser.sv
bench/tb_custom_radix_number_parser.sv
